### rtl/i2cbc_pkg.sv
`default_nettype none

package i2cbc_pkg;

    localparam int unsigned OUT_COUNT_W = 32;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RELEASE    = 4'd1,
        PH_PULSE_LOW  = 4'd2,
        PH_PULSE_HIGH = 4'd3,
        PH_STOP_A     = 4'd4,
        PH_STOP_B     = 4'd5,
        PH_STOP_C     = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE          = 2'd0,
        OP_RECOVER       = 2'd1,
        OP_RECOVER_STUCK = 2'd2,
        OP_UNUSED        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_MAX_PULSES  = 2'd1,
        CFG_HOLDOFF     = 2'd2,
        CFG_NONE        = 2'd3
    } cfg_index_t;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd240;
    localparam logic [7:0]  MAX_PULSES_RST  = 8'd64;
    localparam logic [15:0] HOLDOFF_RST     = 16'd1000;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  max_pulses;
        logic [15:0] holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       scl_level;
        logic       sda_level;
        logic       ctrl_not_ready;
        logic       ctrl_busy;
        logic       ms_strobe;
    } in_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  pulse_index;
        logic [15:0] delay_left;
        logic        sda_released;
        logic        dead_flag;
        logic [15:0] ms_since_recovery;
    } seq_state_t;

    typedef struct packed {
        logic done;
        logic ok;
        logic rej;
        logic reinit;
        logic inc_attempt;
        logic inc_failure;
    } step_flags_t;

endpackage

`default_nettype wire

### rtl/i2cbc_if.sv
`default_nettype none

interface i2cbc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       scl_level;
    logic       sda_level;
    logic       ctrl_not_ready;
    logic       ctrl_busy;
    logic       ms_strobe;

    modport source (
        output valid, opcode, scl_level, sda_level, ctrl_not_ready, ctrl_busy, ms_strobe,
        input  ready
    );
    modport sink (
        input  valid, opcode, scl_level, sda_level, ctrl_not_ready, ctrl_busy, ms_strobe,
        output ready
    );
endinterface

interface i2cbc_rsp_if;
    logic        valid;
    logic        ready;
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        controller_detached;
    logic        reinit_strobe;
    logic        done_res;
    logic        success;
    logic        rejected;
    logic        dead;
    logic [31:0] attempt_count;
    logic [31:0] failure_count;

    modport source (
        output valid, scl_drive_low, sda_drive_low, controller_detached, reinit_strobe,
               done_res, success, rejected, dead, attempt_count, failure_count,
        input  ready
    );
    modport sink (
        input  valid, scl_drive_low, sda_drive_low, controller_detached, reinit_strobe,
               done_res, success, rejected, dead, attempt_count, failure_count,
        output ready
    );
endinterface

interface i2cbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/i2cbc_cfg.sv
`default_nettype none

module i2cbc_cfg
    import i2cbc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    i2cbc_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_HALF_PERIOD: regs_next.half_period_ticks = cfg.data;
                CFG_MAX_PULSES:  regs_next.max_pulses        = cfg.data[7:0];
                CFG_HOLDOFF:     regs_next.holdoff_ms        = cfg.data;
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.half_period_ticks <= HALF_PERIOD_RST;
            regs_reg.max_pulses        <= MAX_PULSES_RST;
            regs_reg.holdoff_ms        <= HOLDOFF_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cbc_step.sv
`default_nettype none

module i2cbc_step
    import i2cbc_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire seq_state_t cur,
    input  wire in_item_t   item,
    output seq_state_t      nxt,
    output step_flags_t     flags
);

    logic [15:0] ms_upd;
    logic [15:0] wait_len;
    logic [7:0]  pulse_inc;
    logic        in_holdoff;
    logic        stuck;
    logic        idle;
    logic        expired;
    logic        start;
    logic        reject;
    logic        quick_ok;
    logic        finish;
    logic        fin_ok;

    always_comb
    begin
        ms_upd = cur.ms_since_recovery;
        if (item.ms_strobe && (cur.ms_since_recovery < cfg.holdoff_ms))
        begin
            ms_upd = cur.ms_since_recovery + 16'd1;
        end
    end

    assign wait_len   = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign pulse_inc  = cur.pulse_index + 8'd1;
    assign in_holdoff = cur.dead_flag && (ms_upd < cfg.holdoff_ms);
    assign stuck      = !item.scl_level || !item.sda_level || item.ctrl_not_ready
                        || item.ctrl_busy;
    assign idle       = (cur.phase == PH_IDLE);
    assign expired    = (cur.delay_left <= 16'd1);

    assign start    = idle && (((opcode_t'(item.opcode) == OP_RECOVER) && !in_holdoff)
                      || ((opcode_t'(item.opcode) == OP_RECOVER_STUCK) && !cur.dead_flag
                          && stuck));
    assign reject   = idle && (((opcode_t'(item.opcode) == OP_RECOVER) && in_holdoff)
                      || ((opcode_t'(item.opcode) == OP_RECOVER_STUCK) && cur.dead_flag));
    assign quick_ok = idle && (opcode_t'(item.opcode) == OP_RECOVER_STUCK)
                      && !cur.dead_flag && !stuck;
    assign finish   = (cur.phase == PH_STOP_C) && expired;
    assign fin_ok   = (item.sda_level || cur.sda_released) && item.scl_level;

    // next state
    always_comb
    begin
        nxt                   = cur;
        nxt.ms_since_recovery = ms_upd;
        if (idle)
        begin
            if (start)
            begin
                nxt.ms_since_recovery = 16'd0;
                nxt.pulse_index       = 8'd0;
                nxt.sda_released      = 1'b0;
                nxt.phase             = PH_RELEASE;
                nxt.delay_left        = wait_len;
            end
        end
        else if (!expired)
        begin
            nxt.delay_left = cur.delay_left - 16'd1;
        end
        else
        begin
            nxt.delay_left = wait_len;
            unique case (cur.phase)
                PH_RELEASE:
                begin
                    nxt.phase = (cfg.max_pulses != 8'd0) ? PH_PULSE_LOW : PH_STOP_A;
                end
                PH_PULSE_LOW:
                begin
                    nxt.phase = PH_PULSE_HIGH;
                end
                PH_PULSE_HIGH:
                begin
                    nxt.pulse_index = pulse_inc;
                    if (item.sda_level)
                    begin
                        nxt.sda_released = 1'b1;
                        nxt.phase        = PH_STOP_A;
                    end
                    else if (pulse_inc < cfg.max_pulses)
                    begin
                        nxt.phase = PH_PULSE_LOW;
                    end
                    else
                    begin
                        nxt.phase = PH_STOP_A;
                    end
                end
                PH_STOP_A:
                begin
                    nxt.phase = PH_STOP_B;
                end
                PH_STOP_B:
                begin
                    nxt.phase = PH_STOP_C;
                end
                PH_STOP_C:
                begin
                    nxt.sda_released = cur.sda_released | item.sda_level;
                    nxt.dead_flag    = !fin_ok;
                    nxt.phase        = PH_IDLE;
                    nxt.delay_left   = 16'd0;
                end
                default:
                begin
                    nxt.phase      = PH_IDLE;
                    nxt.delay_left = 16'd0;
                end
            endcase
        end
    end

    // result flags
    always_comb
    begin
        flags.done        = reject | quick_ok | finish;
        flags.ok          = quick_ok | (finish & fin_ok);
        flags.rej         = reject;
        flags.reinit      = finish;
        flags.inc_attempt = start;
        flags.inc_failure = finish & !fin_ok;
    end

endmodule

`default_nettype wire

### rtl/i2c_bus_clear_sequencer_core.sv
// I2C bus-clear sequencer.
// req: one beat per clock tick of the sequenced bus: opcode, sampled SCL/SDA,
//   controller status and the millisecond strobe.
// rsp: one beat for every req beat, in order: pin drives, detach, re-init
//   strobe, done/success/rejected, dead flag and the two event counters.
// cfg: register writes (0 half period, 1 max pulses, 2 holdoff ms); always
//   ready, to be used only while no req beat is in flight.
// A req beat is held in an input register; the sequencer state and the
//   result register update together when that beat advances, and its rsp
//   beat is then offered from them. One beat per cycle is sustained while
//   rsp is ready; the single pass of next-state logic sets that figure.
// If rsp stalls, the result register holds, a req beat is taken into the
//   input register only if it is empty, and req.ready stays low until rsp moves.
// Reset: sequencer idle, not dead, counters zero, registers at 240 / 64 / 1000.
// COUNT_BITS sets the counter width; rsp counts are zero-extended to 32 bits.
`default_nettype none

module i2c_bus_clear_sequencer_core
    import i2cbc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    i2cbc_req_if.sink   req,
    i2cbc_rsp_if.source rsp,
    i2cbc_cfg_if.sink   cfg
);

    cfg_t                  cfg_regs;
    in_item_t              item_reg;
    logic                  item_valid_reg;
    seq_state_t            state_reg;
    seq_state_t            state_next;
    step_flags_t           flags;
    step_flags_t           flags_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] attempt_cnt_reg;
    logic [COUNT_BITS-1:0] failure_cnt_reg;
    logic                  advance;

    i2cbc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    i2cbc_step u_step (
        .cfg   (cfg_regs),
        .cur   (state_reg),
        .item  (item_reg),
        .nxt   (state_next),
        .flags (flags)
    );

    assign advance   = item_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.opcode         <= req.opcode;
            item_reg.scl_level      <= req.scl_level;
            item_reg.sda_level      <= req.sda_level;
            item_reg.ctrl_not_ready <= req.ctrl_not_ready;
            item_reg.ctrl_busy      <= req.ctrl_busy;
            item_reg.ms_strobe      <= req.ms_strobe;
        end
        if (advance)
        begin
            flags_reg <= flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{phase: PH_IDLE, default: '0};
            attempt_cnt_reg <= '0;
            failure_cnt_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
                if (flags.inc_attempt)
                begin
                    attempt_cnt_reg <= attempt_cnt_reg + COUNT_BITS'(1);
                end
                if (flags.inc_failure)
                begin
                    failure_cnt_reg <= failure_cnt_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.scl_drive_low       = (state_reg.phase == PH_PULSE_LOW)
                                     || (state_reg.phase == PH_STOP_A);
    assign rsp.sda_drive_low       = (state_reg.phase == PH_STOP_A)
                                     || (state_reg.phase == PH_STOP_B);
    assign rsp.controller_detached = (state_reg.phase != PH_IDLE);
    assign rsp.reinit_strobe       = flags_reg.reinit;
    assign rsp.done_res            = flags_reg.done;
    assign rsp.success             = flags_reg.ok;
    assign rsp.rejected            = flags_reg.rej;
    assign rsp.dead                = state_reg.dead_flag;
    assign rsp.attempt_count       = OUT_COUNT_W'(attempt_cnt_reg);
    assign rsp.failure_count       = OUT_COUNT_W'(failure_cnt_reg);

    a_reject_is_failed_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.rejected) |-> (rsp.done_res && !rsp.success))
        else $error("rejected beat without done or with success");

    a_reinit_ends_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.reinit_strobe) |-> (rsp.done_res && !rsp.controller_detached))
        else $error("re-init strobe while sequence still running");

    a_counters_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(attempt_cnt_reg) && $stable(failure_cnt_reg)
                      && $stable(state_reg)))
        else $error("sequencer state moved without a beat");

    a_failure_sets_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && flags.inc_failure) |=> state_reg.dead_flag)
        else $error("failed recovery did not set dead flag");

endmodule

`default_nettype wire
